### hw/rtl/iss_pkg.sv
package iss_pkg;

    localparam int ISS_MAX_SYLLABLE = 16;

    typedef enum logic [2:0] {
        MODE_CLOSED  = 3'd0,
        MODE_VOWMAT  = 3'd1,
        MODE_EXC     = 3'd2,
        MODE_CLUSTER = 3'd3,
        MODE_CLMAT   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        CLS_DEF = 3'd0,
        CLS_CHB = 3'd1,
        CLS_VOW = 3'd2,
        CLS_CON = 3'd3,
        CLS_MAT = 3'd4,
        CLS_HAL = 3'd5,
        CLS_NUK = 3'd6
    } t_class;

    localparam logic [7:0] CHB_LO = 8'd161;
    localparam logic [7:0] CHB_HI = 8'd163;
    localparam logic [7:0] VOW_LO = 8'd164;
    localparam logic [7:0] VOW_HI = 8'd178;
    localparam logic [7:0] CON_LO = 8'd179;
    localparam logic [7:0] CON_HI = 8'd216;
    localparam logic [7:0] MAT_LO = 8'd218;
    localparam logic [7:0] MAT_HI = 8'd231;
    localparam logic [7:0] HALANT = 8'd232;
    localparam logic [7:0] NUKTA  = 8'd233;

    function automatic t_class byte_class(input logic [7:0] b);
        t_class k;
        if (b >= CHB_LO && b <= CHB_HI) begin
            k = CLS_CHB;
        end else if (b >= VOW_LO && b <= VOW_HI) begin
            k = CLS_VOW;
        end else if (b >= CON_LO && b <= CON_HI) begin
            k = CLS_CON;
        end else if (b >= MAT_LO && b <= MAT_HI) begin
            k = CLS_MAT;
        end else if (b == HALANT) begin
            k = CLS_HAL;
        end else if (b == NUKTA) begin
            k = CLS_NUK;
        end else begin
            k = CLS_DEF;
        end
        return k;
    endfunction

    // Bytes that form their own syllable and may take a chandrabindu or a nukta.
    function automatic logic is_exc(input logic [7:0] b);
        return (b == 8'd161) || (b == 8'd166) || (b == 8'd167) ||
               (b == 8'd170) || (b == 8'd234);
    endfunction

    // Cluster heads whose final matra may still take a nukta.
    function automatic logic is_exc_matra_base(input logic [7:0] b);
        return (b == 8'd219) || (b == 8'd220) || (b == 8'd239);
    endfunction

endpackage

### hw/rtl/iss_in_if.sv
interface iss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       run_start;

    modport source (output valid, output code_byte, output run_start, input ready);
    modport sink   (input valid, input code_byte, input run_start, output ready);
endinterface

### hw/rtl/iss_out_if.sv
interface iss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       syllable_start;
    logic       forced_break;

    modport source (output valid, output out_byte, output syllable_start,
                     output forced_break, input ready);
    modport sink   (input valid, input out_byte, input syllable_start,
                     input forced_break, output ready);
endinterface

### hw/rtl/iscii_syllable_segmenter_top.sv
// ISCII syllable segmenter. Bytes of a run enter on i_byte, one per transfer, and
// leave on o_seg in the same order, each unchanged and tagged with syllable_start
// (the byte opens a new syllable) and forced_break (the break came from the
// MAX_SYLLABLE length limit). Set run_start on the first byte of each run. The
// block takes one byte per clock cycle when o_seg is not stalled. A byte is first
// held in the input register and is then loaded into the output register, with
// the segmentation state updated as it passes between them, and it is offered on
// o_seg from the output register. While an output transfer is pending the output
// register stays loaded; the input register can take one more byte, after which
// i_byte stalls until o_seg accepts.
module iscii_syllable_segmenter_top
    import iss_pkg::*;
#(
    parameter int MAX_SYLLABLE = ISS_MAX_SYLLABLE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iss_in_if.sink    i_byte,
    iss_out_if.source o_seg
);

    localparam int LEN_W = $clog2(MAX_SYLLABLE + 1);

    logic             r_s1_valid;
    logic [7:0]       r_s1_byte;
    logic             r_s1_run;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_start;
    logic             r_out_forced;

    t_mode            r_mode;
    logic             r_halant;
    logic [7:0]       r_first_byte;
    logic [LEN_W-1:0] r_len;

    t_mode            n_mode;
    logic             n_halant;
    logic [7:0]       n_first_byte;
    logic [LEN_W-1:0] n_len;
    logic             n_start;
    logic             n_forced;

    t_class           klass;
    t_mode            cur_mode;
    logic             cur_halant;
    logic             joins;
    t_mode            j_mode;
    logic             j_halant;
    logic             s1_adv;

    assign s1_adv       = r_s1_valid && (!r_out_valid || o_seg.ready);
    assign i_byte.ready = !r_s1_valid || s1_adv;

    assign o_seg.valid          = r_out_valid;
    assign o_seg.out_byte       = r_out_byte;
    assign o_seg.syllable_start = r_out_start;
    assign o_seg.forced_break   = r_out_forced;

    always_comb begin
        n_forced = joins && (r_len >= LEN_W'(MAX_SYLLABLE));
        n_start  = !joins || n_forced;
    end

    always_comb begin
        klass      = byte_class(r_s1_byte);
        cur_mode   = r_s1_run ? MODE_CLOSED : r_mode;
        cur_halant = r_s1_run ? 1'b0 : r_halant;
        joins      = 1'b0;
        j_mode     = cur_mode;
        j_halant   = cur_halant;

        case (cur_mode)
            MODE_VOWMAT: begin
                if (klass == CLS_CHB) begin
                    joins  = 1'b1;
                    j_mode = MODE_CLOSED;
                end
            end
            MODE_EXC: begin
                if (klass == CLS_CHB || klass == CLS_NUK) begin
                    joins  = 1'b1;
                    j_mode = MODE_CLOSED;
                end
            end
            MODE_CLMAT: begin
                if (klass == CLS_CHB ||
                    (klass == CLS_NUK && is_exc_matra_base(r_first_byte))) begin
                    joins  = 1'b1;
                    j_mode = MODE_CLOSED;
                end
            end
            MODE_CLUSTER: begin
                case (klass)
                    CLS_CHB: begin
                        joins  = 1'b1;
                        j_mode = MODE_CLOSED;
                    end
                    CLS_MAT: begin
                        joins  = 1'b1;
                        j_mode = MODE_CLMAT;
                    end
                    CLS_NUK: begin
                        joins = 1'b1;
                    end
                    CLS_HAL: begin
                        joins    = 1'b1;
                        j_halant = 1'b1;
                    end
                    CLS_CON: begin
                        if (cur_halant) begin
                            joins    = 1'b1;
                            j_halant = 1'b0;
                        end
                    end
                    CLS_VOW: begin
                    end
                    default: begin
                        // A default byte ends the cluster and drops any pending halant.
                        j_halant = 1'b0;
                    end
                endcase
            end
            default: begin
            end
        endcase

        n_mode       = j_mode;
        n_halant     = j_halant;
        n_first_byte = r_first_byte;
        n_len        = r_len + LEN_W'(1);

        if (n_start) begin
            if (n_forced) begin
                n_halant = 1'b0;
            end
            n_len = LEN_W'(1);
            if (is_exc(r_s1_byte)) begin
                n_mode = MODE_EXC;
            end else begin
                case (klass)
                    CLS_VOW, CLS_MAT: begin
                        n_mode = MODE_VOWMAT;
                    end
                    CLS_CON: begin
                        n_mode       = MODE_CLUSTER;
                        n_first_byte = r_s1_byte;
                    end
                    default: begin
                        n_mode = MODE_CLOSED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= MODE_CLOSED;
            r_halant     <= 1'b0;
            r_first_byte <= 8'd0;
            r_len        <= '0;
        end else begin
            if (i_byte.valid && i_byte.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid  <= 1'b1;
                r_mode       <= n_mode;
                r_halant     <= n_halant;
                r_first_byte <= n_first_byte;
                r_len        <= n_len;
            end else if (o_seg.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_s1_byte <= i_byte.code_byte;
            r_s1_run  <= i_byte.run_start;
        end
        if (s1_adv) begin
            r_out_byte   <= r_s1_byte;
            r_out_start  <= n_start;
            r_out_forced <= n_forced;
        end
    end

endmodule

### tb/sv/iscii_syllable_segmenter_top_tb.sv
`timescale 1ns / 1ps

module iscii_syllable_segmenter_top_tb;
    import iss_pkg::*;

    localparam int SEG_MAX        = ISS_MAX_SYLLABLE;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int LONG_HOLD      = 90;
    localparam int DRAIN_POINT_A  = 700;
    localparam int DRAIN_POINT_B  = 1500;

    typedef struct {
        logic [7:0] code;
        logic       run_start;
        bit         wait_drain;
    } t_pending_byte;

    typedef struct {
        logic [7:0] code;
        logic       syl_start;
        logic       forced;
    } t_seg_result;

    logic i_clk;
    logic i_rst_n;

    iss_in_if  byte_ch ();
    iss_out_if seg_ch ();

    iscii_syllable_segmenter_top #(
        .MAX_SYLLABLE(SEG_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_seg   (seg_ch)
    );

    t_pending_byte pending_q[$];
    t_seg_result   expected_seg_q[$];

    // Segmentation state as the block should hold it.
    t_mode      seg_mode     = MODE_CLOSED;
    bit         halant_held  = 1'b0;
    logic [7:0] cluster_head = 8'd0;
    logic [4:0] syl_len      = 5'd0;

    int  errors         = 0;
    int  cycle_count    = 0;
    int  bytes_accepted = 0;
    bit  new_run        = 1'b1;
    bit  drain_next     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic t_class classify(input logic [7:0] b);
        if (b >= CHB_LO && b <= CHB_HI) return CLS_CHB;
        if (b >= VOW_LO && b <= VOW_HI) return CLS_VOW;
        if (b >= CON_LO && b <= CON_HI) return CLS_CON;
        if (b >= MAT_LO && b <= MAT_HI) return CLS_MAT;
        if (b == HALANT) return CLS_HAL;
        if (b == NUKTA) return CLS_NUK;
        return CLS_DEF;
    endfunction

    function automatic bit exc_letter(input logic [7:0] b);
        return b == 8'd161 || b == 8'd166 || b == 8'd167 || b == 8'd170 || b == 8'd234;
    endfunction

    function automatic bit nukta_matra_head(input logic [7:0] b);
        return b == 8'd219 || b == 8'd220 || b == 8'd239;
    endfunction

    // Works out the tag of one byte and moves the segmentation state on.
    function automatic t_seg_result segment_byte(input logic [7:0] b, input logic rs);
        t_seg_result r;
        t_class      k;
        t_mode       mode_saved;
        bit          halant_saved;
        bit          joined;
        k = classify(b);
        joined = 1'b0;
        r.code = b;
        r.syl_start = 1'b1;
        r.forced = 1'b0;
        if (rs) begin
            seg_mode = MODE_CLOSED;
            halant_held = 1'b0;
        end
        mode_saved = seg_mode;
        halant_saved = halant_held;
        case (seg_mode)
            MODE_VOWMAT: begin
                if (k == CLS_CHB) begin
                    joined = 1'b1;
                    seg_mode = MODE_CLOSED;
                end
            end
            MODE_EXC: begin
                if (k == CLS_CHB || k == CLS_NUK) begin
                    joined = 1'b1;
                    seg_mode = MODE_CLOSED;
                end
            end
            MODE_CLMAT: begin
                if (k == CLS_CHB || (k == CLS_NUK && nukta_matra_head(cluster_head))) begin
                    joined = 1'b1;
                    seg_mode = MODE_CLOSED;
                end
            end
            MODE_CLUSTER: begin
                case (k)
                    CLS_CHB: begin
                        joined = 1'b1;
                        seg_mode = MODE_CLOSED;
                    end
                    CLS_MAT: begin
                        joined = 1'b1;
                        seg_mode = MODE_CLMAT;
                    end
                    CLS_NUK: joined = 1'b1;
                    CLS_HAL: begin
                        joined = 1'b1;
                        halant_held = 1'b1;
                    end
                    CLS_CON: begin
                        if (halant_held) begin
                            joined = 1'b1;
                            halant_held = 1'b0;
                        end
                    end
                    CLS_VOW: ;
                    default: halant_held = 1'b0;
                endcase
            end
            default: ;
        endcase
        if (joined) begin
            if (syl_len >= SEG_MAX) begin
                // The syllable is full: undo the join and open a new one.
                seg_mode = mode_saved;
                halant_held = halant_saved;
                r.forced = 1'b1;
            end else begin
                syl_len = syl_len + 5'd1;
                r.syl_start = 1'b0;
            end
        end
        if (r.syl_start) begin
            if (r.forced) halant_held = 1'b0;
            syl_len = 5'd1;
            if (exc_letter(b)) begin
                seg_mode = MODE_EXC;
            end else begin
                case (k)
                    CLS_VOW, CLS_MAT: seg_mode = MODE_VOWMAT;
                    CLS_CON: begin
                        seg_mode = MODE_CLUSTER;
                        cluster_head = b;
                    end
                    default: seg_mode = MODE_CLOSED;
                endcase
            end
        end
        return r;
    endfunction

    // Input transfers feed the predictor; output transfers are checked.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL iscii_syllable_segmenter_top");
            $finish;
        end
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                expected_seg_q.push_back(segment_byte(byte_ch.code_byte, byte_ch.run_start));
                bytes_accepted <= bytes_accepted + 1;
            end
            if (seg_ch.valid && seg_ch.ready) begin
                if (expected_seg_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %0d", seg_ch.out_byte));
                end else begin
                    t_seg_result want;
                    want = expected_seg_q.pop_front();
                    if (seg_ch.out_byte !== want.code ||
                        seg_ch.syllable_start !== want.syl_start ||
                        seg_ch.forced_break !== want.forced) begin
                        report_mismatch($sformatf(
                            "byte %0d start %b forced %b, wanted byte %0d start %b forced %b",
                            seg_ch.out_byte, seg_ch.syllable_start, seg_ch.forced_break,
                            want.code, want.syl_start, want.forced));
                    end
                end
            end
        end
    end

    // Sender: bursts of transfers with random gaps, fed from the pending queue.
    int taken_seen = 0;
    int burst_left = 8;
    int gap_left   = 0;
    bit offering   = 1'b0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (bytes_accepted != taken_seen) begin
                taken_seen = bytes_accepted;
                void'(pending_q.pop_front());
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0 &&
                             !(pending_q[0].wait_drain && expected_seg_q.size() != 0)) begin
                    offering = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
            byte_ch.valid <= offering;
            if (offering) begin
                byte_ch.code_byte <= pending_q[0].code;
                byte_ch.run_start <= pending_q[0].run_start;
            end else begin
                byte_ch.code_byte <= 8'($urandom_range(0, 255));
                byte_ch.run_start <= 1'($urandom_range(0, 1));
            end
        end
    end

    // Receiver: stall pattern chosen per phase, plus two long hold-offs.
    int rx_style      = 0;
    int rx_phase_left = 0;
    int rx_hold_left  = 0;
    bit rx_toggle     = 1'b0;
    bit [1:0] rx_hold_done = 2'b00;

    always @(negedge i_clk) begin
        if (!rx_hold_done[0] && bytes_accepted >= 400) begin
            rx_hold_done[0] = 1'b1;
            rx_hold_left = LONG_HOLD;
        end
        if (!rx_hold_done[1] && bytes_accepted >= 1300) begin
            rx_hold_done[1] = 1'b1;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            seg_ch.ready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_phase_left = $urandom_range(10, 120);
            end else begin
                rx_phase_left--;
            end
            rx_toggle = ~rx_toggle;
            case (rx_style)
                0: seg_ch.ready <= 1'b1;
                1: seg_ch.ready <= ($urandom_range(0, 3) != 0);
                2: seg_ch.ready <= ($urandom_range(0, 3) == 0);
                default: seg_ch.ready <= rx_toggle;
            endcase
        end
    end

    task automatic push_byte(input logic [7:0] b);
        t_pending_byte it;
        it.code = b;
        it.run_start = new_run;
        it.wait_drain = drain_next;
        new_run = 1'b0;
        drain_next = 1'b0;
        pending_q.push_back(it);
    endtask

    function automatic logic [7:0] pick_exc();
        case ($urandom_range(0, 4))
            0: return 8'd161;
            1: return 8'd166;
            2: return 8'd167;
            3: return 8'd170;
            default: return 8'd234;
        endcase
    endfunction

    // One syllable, mostly well formed, sometimes noise or broken by a new run.
    task automatic gen_syllable();
        int kind;
        int joins;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            push_byte(8'($urandom_range(VOW_LO, VOW_HI)));
            if ($urandom_range(0, 1)) push_byte(8'($urandom_range(CHB_LO, CHB_HI)));
        end else if (kind < 25) begin
            push_byte(pick_exc());
            case ($urandom_range(0, 2))
                1: push_byte(8'($urandom_range(CHB_LO, CHB_HI)));
                2: push_byte(NUKTA);
                default: ;
            endcase
        end else if (kind < 33) begin
            push_byte(8'($urandom_range(MAT_LO, MAT_HI)));
            if ($urandom_range(0, 1)) push_byte(8'($urandom_range(CHB_LO, CHB_HI)));
        end else if (kind < 85) begin
            push_byte(8'($urandom_range(CON_LO, CON_HI)));
            // A long cluster now and then runs into the length limit.
            joins = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 3);
            repeat (joins) begin
                if ($urandom_range(0, 32) == 0) new_run = 1'b1;
                if ($urandom_range(0, 2) == 0) begin
                    push_byte(NUKTA);
                end else begin
                    push_byte(HALANT);
                    push_byte(8'($urandom_range(CON_LO, CON_HI)));
                end
            end
            case ($urandom_range(0, 4))
                1, 2: begin
                    push_byte(8'($urandom_range(MAT_LO, MAT_HI)));
                    case ($urandom_range(0, 2))
                        1: push_byte(8'($urandom_range(CHB_LO, CHB_HI)));
                        2: push_byte(NUKTA);
                        default: ;
                    endcase
                end
                3: push_byte(8'($urandom_range(CHB_LO, CHB_HI)));
                4: push_byte(HALANT);
                default: ;
            endcase
        end else begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0] directed_bytes[$];
        int drain_marks;
        directed_bytes = '{8'd0, 8'd255, HALANT, NUKTA, 8'd162, 8'd164, 8'd161,
                           8'd166, NUKTA, 8'd179, HALANT, 8'd216};
        drain_marks = 0;
        i_rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.code_byte = 8'd0;
        byte_ch.run_start = 1'b0;
        seg_ch.ready = 1'b0;

        // Lone signs and bytes, then a cluster that reaches the length limit
        // and is cut by a matra.
        foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
        repeat (13) push_byte(NUKTA);
        push_byte(8'd218);
        push_byte(8'd163);

        while (pending_q.size() < RANDOM_ITEMS + 27) begin
            if ($urandom_range(0, 5) == 0) new_run = 1'b1;
            if ((drain_marks == 0 && pending_q.size() >= DRAIN_POINT_A) ||
                (drain_marks == 1 && pending_q.size() >= DRAIN_POINT_B)) begin
                drain_next = 1'b1;
                drain_marks++;
            end
            gen_syllable();
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_q.size() != 0) @(posedge i_clk);
        while (expected_seg_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS iscii_syllable_segmenter_top");
        end else begin
            $display("FAIL iscii_syllable_segmenter_top");
        end
        $finish;
    end

endmodule
